// File: design/gcl_pkg.sv
// Shared types and codes for the graph-convolution layer unit.
// No dependencies.
`default_nettype none
package gcl_pkg;

  localparam int unsigned CntW = 7;

  // action codes
  localparam logic [2:0] ActLoadFeat = 3'd0;
  localparam logic [2:0] ActLoadWgt  = 3'd1;
  localparam logic [2:0] ActLoadAdj  = 3'd2;
  localparam logic [2:0] ActCompute  = 3'd3;
  localparam logic [2:0] ActRead     = 3'd4;

  // register indexes
  localparam logic [1:0] RegNodeCnt = 2'd0;
  localparam logic [1:0] RegInCnt   = 2'd1;
  localparam logic [1:0] RegOutCnt  = 2'd2;

  // result kinds
  localparam logic KindDone = 1'b0;
  localparam logic KindRead = 1'b1;

  typedef struct packed {
    logic [2:0]         action;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] result_value;
    logic               saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_P1,
    S_W1,
    S_P2,
    S_W2
  } seq_state_e;

endpackage
`default_nettype wire

// File: design/graph_conv_layer_matmul_unit.sv
// Graph-convolution layer: support = features x weight, output = adj x support.
// Depends on gcl_pkg.
`default_nettype none
//
//  channel | signals                          | dir | notes
//  --------+----------------------------------+-----+-------------------------
//  in      | in_valid_i/in_ready_o/in_data_i  | in  | load, compute, read
//  out     | out_valid_o/out_ready_i/out_data_o| out| compute done, read data
//  cfg     | cfg_we_i/cfg_idx_i/cfg_data_i    | in  | counts, no read-back
//
//  A load writes its store at the handshake. A read first does a synchronous
//  read of the output store, then lands in the output register.
//  A compute walks the stores through one shared multiply-accumulate pipe
//  and drains it after each phase. Reset clears control and the
//  saturation flag, sets counts to 64 capped at their maxima; stores hold
//  junk until written. A stalled result blocks every item, loads included.
module graph_conv_layer_matmul_unit
  import gcl_pkg::*;
#(
  parameter int unsigned MAX_NODES        = 64,
  parameter int unsigned MAX_IN_FEATURES  = 64,
  parameter int unsigned MAX_OUT_FEATURES = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [CntW-1:0]  cfg_data_i
);

  localparam int unsigned FeatD = MAX_NODES * MAX_IN_FEATURES;
  localparam int unsigned WgtD  = MAX_IN_FEATURES * MAX_OUT_FEATURES;
  localparam int unsigned AdjD  = MAX_NODES * MAX_NODES;
  localparam int unsigned SupD  = MAX_NODES * MAX_OUT_FEATURES;
  localparam int unsigned FeatAw = $clog2(FeatD);
  localparam int unsigned WgtAw  = $clog2(WgtD);
  localparam int unsigned AdjAw  = $clog2(AdjD);
  localparam int unsigned SupAw  = $clog2(SupD);

  function automatic logic [CntW-1:0] clamp_cnt(input logic [CntW-1:0] v,
                                                input int unsigned mx);
    logic [CntW-1:0] r;
    r = v;
    if (v == '0) r = CntW'(1);
    else if (32'(v) > mx) r = CntW'(mx);
    return r;
  endfunction

  // ---- configuration
  logic [CntW-1:0] node_cnt_q, in_cnt_q, out_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_cnt_q <= clamp_cnt(CntW'(64), MAX_NODES);
      in_cnt_q   <= clamp_cnt(CntW'(64), MAX_IN_FEATURES);
      out_cnt_q  <= clamp_cnt(CntW'(64), MAX_OUT_FEATURES);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegNodeCnt) node_cnt_q <= clamp_cnt(cfg_data_i, MAX_NODES);
      if (cfg_idx_i == RegInCnt)   in_cnt_q   <= clamp_cnt(cfg_data_i, MAX_IN_FEATURES);
      if (cfg_idx_i == RegOutCnt)  out_cnt_q  <= clamp_cnt(cfg_data_i, MAX_OUT_FEATURES);
    end
  end

  // ---- control
  seq_state_e state_q, state_d;
  logic rd_pend_q, rd_zero_q, sat_q;
  logic out_valid_q;
  out_item_t out_q;
  logic in_xfer, rd_go, cp_go;

  assign in_ready_o = (state_q == S_IDLE) && !rd_pend_q && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign rd_go      = in_xfer && (in_data_i.action == ActRead);
  assign cp_go      = in_xfer && (in_data_i.action == ActCompute);

  // issue counters
  logic [CntW-1:0] i_q, j_q, k_q, i_d, j_d, k_d, kmax;
  logic issue, last_k, last_j, last_i;
  assign kmax   = (state_q == S_P2) ? node_cnt_q : in_cnt_q;
  assign issue  = (state_q == S_P1) || (state_q == S_P2);
  assign last_k = (k_q == kmax - CntW'(1));
  assign last_j = (j_q == out_cnt_q - CntW'(1));
  assign last_i = (i_q == node_cnt_q - CntW'(1));

  // pipeline tags: b aligns with memory data, c with the product
  logic b_vld_q, b_first_q, b_last_q, b_ph2_q;
  logic c_vld_q, c_first_q, c_last_q, c_ph2_q;
  logic [SupAw-1:0] b_dst_q, c_dst_q;
  logic drained;
  assign drained = !b_vld_q && !c_vld_q;

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; k_d = k_q;
    if (issue) begin
      k_d = k_q + CntW'(1);
      if (last_k) begin
        k_d = '0;
        j_d = j_q + CntW'(1);
        if (last_j) begin
          j_d = '0;
          i_d = i_q + CntW'(1);
          if (last_i) i_d = '0;
        end
      end
    end
    unique case (state_q)
      S_IDLE: if (cp_go) begin
        state_d = S_P1;
        i_d = '0; j_d = '0; k_d = '0;
      end
      S_P1: if (last_k && last_j && last_i) state_d = S_W1;
      S_W1: if (drained) state_d = S_P2;
      S_P2: if (last_k && last_j && last_i) state_d = S_W2;
      S_W2: if (drained) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q <= '0; j_q <= '0; k_q <= '0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d;
      b_vld_q <= issue;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_first_q <= (k_q == '0);
    b_last_q  <= last_k;
    b_ph2_q   <= (state_q == S_P2);
    b_dst_q   <= SupAw'(SupAw'(i_q) * SupAw'(MAX_OUT_FEATURES)) + SupAw'(j_q);
    c_first_q <= b_first_q;
    c_last_q  <= b_last_q;
    c_ph2_q   <= b_ph2_q;
    c_dst_q   <= b_dst_q;
  end

  // ---- stores
  logic [31:0] feat_mem [FeatD];
  logic [31:0] wgt_mem  [WgtD];
  logic [31:0] adj_mem  [AdjD];
  logic [31:0] sup_mem  [SupD];
  logic [31:0] out_mem  [SupD];
  logic [31:0] feat_rd_q, wgt_rd_q, adj_rd_q, sup_rd_q, out_rd_q;

  logic [FeatAw-1:0] ld_feat_a, cp_feat_a;
  logic [WgtAw-1:0]  ld_wgt_a, cp_wgt_a;
  logic [AdjAw-1:0]  ld_adj_a, cp_adj_a;
  logic [SupAw-1:0]  cp_sup_a, rd_out_a;

  assign ld_feat_a = FeatAw'(FeatAw'(in_data_i.row) * FeatAw'(MAX_IN_FEATURES))
                     + FeatAw'(in_data_i.col);
  assign ld_wgt_a  = WgtAw'(WgtAw'(in_data_i.row) * WgtAw'(MAX_OUT_FEATURES))
                     + WgtAw'(in_data_i.col);
  assign ld_adj_a  = AdjAw'(AdjAw'(in_data_i.row) * AdjAw'(MAX_NODES))
                     + AdjAw'(in_data_i.col);
  assign rd_out_a  = SupAw'(SupAw'(in_data_i.row) * SupAw'(MAX_OUT_FEATURES))
                     + SupAw'(in_data_i.col);
  assign cp_feat_a = FeatAw'(FeatAw'(i_q) * FeatAw'(MAX_IN_FEATURES)) + FeatAw'(k_q);
  assign cp_wgt_a  = WgtAw'(WgtAw'(k_q) * WgtAw'(MAX_OUT_FEATURES)) + WgtAw'(j_q);
  assign cp_adj_a  = AdjAw'(AdjAw'(i_q) * AdjAw'(MAX_NODES)) + AdjAw'(k_q);
  assign cp_sup_a  = SupAw'(SupAw'(k_q) * SupAw'(MAX_OUT_FEATURES)) + SupAw'(j_q);

  logic ld_feat, ld_wgt, ld_adj;
  assign ld_feat = in_xfer && (in_data_i.action == ActLoadFeat)
                   && (32'(in_data_i.row) < MAX_NODES)
                   && (32'(in_data_i.col) < MAX_IN_FEATURES);
  assign ld_wgt  = in_xfer && (in_data_i.action == ActLoadWgt)
                   && (32'(in_data_i.row) < MAX_IN_FEATURES)
                   && (32'(in_data_i.col) < MAX_OUT_FEATURES);
  assign ld_adj  = in_xfer && (in_data_i.action == ActLoadAdj)
                   && (32'(in_data_i.row) < MAX_NODES)
                   && (32'(in_data_i.col) < MAX_NODES);

  // accumulate and saturate
  logic signed [63:0] prod_q, acc_q, sum;
  logic signed [31:0] sat_val;
  logic sum_hi, sum_lo, wr_res;
  assign sum    = (c_first_q ? 64'sd0 : acc_q) + (prod_q >>> 16);
  assign sum_hi = sum > 64'sd2147483647;
  assign sum_lo = sum < -64'sd2147483648;
  assign sat_val = sum_hi ? 32'sh7fffffff : sum_lo ? 32'sh80000000 : sum[31:0];
  assign wr_res = c_vld_q && c_last_q;

  always_ff @(posedge clk_i) begin
    if (ld_feat) feat_mem[ld_feat_a] <= in_data_i.value;
    if (ld_wgt)  wgt_mem[ld_wgt_a]   <= in_data_i.value;
    if (ld_adj)  adj_mem[ld_adj_a]   <= in_data_i.value;
    if (wr_res && !c_ph2_q) sup_mem[c_dst_q] <= sat_val;
    if (wr_res && c_ph2_q)  out_mem[c_dst_q] <= sat_val;
    feat_rd_q <= feat_mem[cp_feat_a];
    wgt_rd_q  <= wgt_mem[cp_wgt_a];
    adj_rd_q  <= adj_mem[cp_adj_a];
    sup_rd_q  <= sup_mem[cp_sup_a];
    out_rd_q  <= out_mem[rd_out_a];
    prod_q <= b_ph2_q ? $signed(adj_rd_q) * $signed(sup_rd_q)
                      : $signed(feat_rd_q) * $signed(wgt_rd_q);
    if (c_vld_q) acc_q <= sum;
  end

  // ---- saturation flag and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      rd_zero_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cp_go) sat_q <= 1'b0;
      else if (wr_res && (sum_hi || sum_lo)) sat_q <= 1'b1;
      rd_pend_q <= rd_go;
      if (rd_go) rd_zero_q <= !((7'(in_data_i.row) < node_cnt_q)
                                && (7'(in_data_i.col) < out_cnt_q));
      if (rd_pend_q || (state_q == S_W2 && drained)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      out_q.kind         <= KindRead;
      out_q.result_value <= rd_zero_q ? 32'sd0 : $signed(out_rd_q);
      out_q.saturated    <= sat_q;
    end else if (state_q == S_W2 && drained) begin
      out_q.kind         <= KindDone;
      out_q.result_value <= 32'sd0;
      out_q.saturated    <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---- checks
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("input taken mid-compute");
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> out_valid_o) else $error("read result lost");
  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !c_vld_q) else $error("pipe busy while idle");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (!out_valid_q || out_ready_i)) else $error("result overwrite");

endmodule
`default_nettype wire
